>>> design/atg_pkg.sv
package atg_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned COUNT_W = 64;
    localparam int unsigned DIV_W = 15;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned IRQ_W = 2;

    localparam logic [DIV_W-1:0] DIV_MAX = 15'd32767;
    localparam logic [DIV_W-1:0] DIV_MIN = 15'd1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [ADDR_W-1:0] REG_CTRL       = 4'd0;
    localparam logic [ADDR_W-1:0] REG_SNAP_LO    = 4'd1;
    localparam logic [ADDR_W-1:0] REG_SNAP_HI    = 4'd2;
    localparam logic [ADDR_W-1:0] REG_UPDATE     = 4'd3;
    localparam logic [ADDR_W-1:0] REG_ALARM_LO   = 4'd4;
    localparam logic [ADDR_W-1:0] REG_ALARM_HI   = 4'd5;
    localparam logic [ADDR_W-1:0] REG_LOAD_LO    = 4'd6;
    localparam logic [ADDR_W-1:0] REG_LOAD_HI    = 4'd7;
    localparam logic [ADDR_W-1:0] REG_LOAD_PULSE = 4'd8;
    localparam logic [ADDR_W-1:0] REG_INT_ENA    = 4'd9;
    localparam logic [ADDR_W-1:0] REG_INT_RAW    = 4'd10;
    localparam logic [ADDR_W-1:0] REG_INT_CLR    = 4'd11;

    localparam int unsigned CTRL_EN_BIT     = 31;
    localparam int unsigned CTRL_UP_BIT     = 30;
    localparam int unsigned CTRL_AR_BIT     = 29;
    localparam int unsigned CTRL_DIV_MSB    = 28;
    localparam int unsigned CTRL_DIV_LSB    = 13;
    localparam int unsigned CTRL_PRE_RST_BIT = 12;
    localparam int unsigned CTRL_AL_BIT     = 10;

    typedef struct packed {
        logic              tick;
        logic              wr;
        logic [ADDR_W-1:0] addr;
    } atg_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  interrupt_lines;
    } atg_rsp_t;

endpackage

>>> design/atg_req_if.sv
interface atg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        timer_index;
    logic [3:0]  register_address;
    logic [31:0] write_data;

    modport source (
        output valid,
        output action,
        output timer_index,
        output register_address,
        output write_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  timer_index,
        input  register_address,
        input  write_data,
        output ready
    );
endinterface

>>> design/atg_rsp_if.sv
interface atg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  interrupt_lines;

    modport source (
        output valid,
        output read_data,
        output interrupt_lines,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  interrupt_lines,
        output ready
    );
endinterface

>>> design/atg_timer.sv
module atg_timer (
    input  logic               clk,
    input  logic               rst_n,
    input  atg_pkg::atg_cmd_t  cmd,
    input  logic [31:0]        wdata,
    output logic [31:0]        rdata,
    output logic               fire
);
    import atg_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] snap_reg, snap_next;
    logic [COUNT_W-1:0] alarm_reg, alarm_next;
    logic [COUNT_W-1:0] load_reg, load_next;
    logic [DIV_W-1:0]   pre_reg, pre_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic               en_reg, en_next;
    logic               up_reg, up_next;
    logic               ar_reg, ar_next;
    logic               al_reg, al_next;

    logic [DIV_W:0]     pre_inc;
    logic               pre_wrap;
    logic [COUNT_W-1:0] stepped;
    logic               hit;
    logic [DIV_W:0]     div_field;
    logic [DIV_W-1:0]   div_clamped;

    assign pre_inc  = {1'b0, pre_reg} + {{DIV_W{1'b0}}, 1'b1};
    assign pre_wrap = pre_inc >= {1'b0, div_reg};
    assign stepped  = !pre_wrap ? count_reg
                    : (up_reg ? count_reg + 64'd1 : count_reg - 64'd1);
    assign hit      = al_reg && (stepped == alarm_reg);
    assign fire     = cmd.tick && en_reg && hit;

    assign div_field = wdata[CTRL_DIV_MSB:CTRL_DIV_LSB];

    always_comb
    begin
        if (div_field == '0)
        begin
            div_clamped = DIV_MIN;
        end
        else if (div_field[DIV_W])
        begin
            div_clamped = DIV_MAX;
        end
        else
        begin
            div_clamped = div_field[DIV_W-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        snap_next  = snap_reg;
        alarm_next = alarm_reg;
        load_next  = load_reg;
        pre_next   = pre_reg;
        div_next   = div_reg;
        en_next    = en_reg;
        up_next    = up_reg;
        ar_next    = ar_reg;
        al_next    = al_reg;

        if (cmd.tick && en_reg)
        begin
            pre_next   = pre_wrap ? '0 : pre_inc[DIV_W-1:0];
            count_next = stepped;
            if (hit)
            begin
                al_next = 1'b0;
                if (ar_reg)
                begin
                    count_next = load_reg;
                end
            end
        end

        if (cmd.wr)
        begin
            unique case (cmd.addr)
                REG_CTRL:
                begin
                    en_next  = wdata[CTRL_EN_BIT];
                    up_next  = wdata[CTRL_UP_BIT];
                    ar_next  = wdata[CTRL_AR_BIT];
                    al_next  = wdata[CTRL_AL_BIT];
                    div_next = div_clamped;
                    if (wdata[CTRL_PRE_RST_BIT])
                    begin
                        pre_next = '0;
                    end
                end
                REG_UPDATE:     snap_next  = count_reg;
                REG_ALARM_LO:   alarm_next = {alarm_reg[63:32], wdata};
                REG_ALARM_HI:   alarm_next = {wdata, alarm_reg[31:0]};
                REG_LOAD_LO:    load_next  = {load_reg[63:32], wdata};
                REG_LOAD_HI:    load_next  = {wdata, load_reg[31:0]};
                REG_LOAD_PULSE: count_next = load_reg;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.addr)
            REG_CTRL:     rdata = {en_reg, up_reg, ar_reg, 1'b0, div_reg, 2'b00, al_reg, 10'd0};
            REG_SNAP_LO:  rdata = snap_reg[31:0];
            REG_SNAP_HI:  rdata = snap_reg[63:32];
            REG_ALARM_LO: rdata = alarm_reg[31:0];
            REG_ALARM_HI: rdata = alarm_reg[63:32];
            REG_LOAD_LO:  rdata = load_reg[31:0];
            REG_LOAD_HI:  rdata = load_reg[63:32];
            default:      rdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            snap_reg  <= '0;
            alarm_reg <= '0;
            load_reg  <= '0;
            pre_reg   <= '0;
            div_reg   <= DIV_MIN;
            en_reg    <= 1'b0;
            up_reg    <= 1'b0;
            ar_reg    <= 1'b0;
            al_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            snap_reg  <= snap_next;
            alarm_reg <= alarm_next;
            load_reg  <= load_next;
            pre_reg   <= pre_next;
            div_reg   <= div_next;
            en_reg    <= en_next;
            up_reg    <= up_next;
            ar_reg    <= ar_next;
            al_reg    <= al_next;
        end
    end

endmodule

>>> design/alarm_timer_group_top.sv
// A group of NUM_TIMERS 64-bit timers with prescalers and alarms, driven by a
// stream of beats that are each a timer tick, a register write or a register
// read. One beat is accepted every cycle while the second response slot is
// empty, and its response goes into the output register; that slot lets the
// block take one more beat while the output is stalled. Each beat is handled
// by the per-timer prescaler step, the 64-bit counter step and the 64-bit
// alarm compare, which together set the clock period.
module alarm_timer_group_top #(
    parameter int unsigned NUM_TIMERS = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    atg_req_if.sink   req,
    atg_rsp_if.source rsp
);
    import atg_pkg::*;

    atg_cmd_t               tick_cmd;
    logic [NUM_TIMERS-1:0]  tmr_wr;
    logic [NUM_TIMERS-1:0]  tmr_sel;
    logic [NUM_TIMERS-1:0]  tmr_fire;
    logic [DATA_W-1:0]      tmr_rd [NUM_TIMERS];

    logic [NUM_TIMERS-1:0]  ien_reg, ien_next;
    logic [NUM_TIMERS-1:0]  raw_reg, raw_next;

    logic                   in_accept;
    logic                   out_pop;
    logic                   here;
    logic [DATA_W-1:0]      rd_timer;
    atg_rsp_t               rsp_new;

    logic                   out_valid_reg;
    atg_rsp_t               out_data_reg;
    logic                   skid_valid_reg;
    atg_rsp_t               skid_data_reg;

    assign req.ready = !skid_valid_reg;
    assign in_accept = req.valid && req.ready;
    assign out_pop   = out_valid_reg && rsp.ready;
    assign here      = 32'(req.timer_index) < NUM_TIMERS;

    assign tick_cmd.tick = in_accept && (req.action == ACT_TICK);
    assign tick_cmd.wr   = 1'b0;
    assign tick_cmd.addr = req.register_address;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_timer
        atg_cmd_t cmd;

        assign tmr_sel[i] = 32'(req.timer_index) == i;
        assign tmr_wr[i]  = in_accept && (req.action == ACT_WRITE) && tmr_sel[i];

        always_comb
        begin
            cmd    = tick_cmd;
            cmd.wr = tmr_wr[i];
        end

        atg_timer u_timer (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .wdata (req.write_data),
            .rdata (tmr_rd[i]),
            .fire  (tmr_fire[i])
        );
    end

    always_comb
    begin
        rd_timer = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (tmr_sel[i])
            begin
                rd_timer = rd_timer | tmr_rd[i];
            end
        end
    end

    always_comb
    begin
        ien_next = ien_reg;
        raw_next = raw_reg;
        if (tick_cmd.tick)
        begin
            raw_next = raw_reg | tmr_fire;
        end
        else if (in_accept && (req.action == ACT_WRITE))
        begin
            if (req.register_address == REG_INT_ENA)
            begin
                ien_next = req.write_data[NUM_TIMERS-1:0];
            end
            else if (req.register_address == REG_INT_CLR)
            begin
                raw_next = raw_reg & ~req.write_data[NUM_TIMERS-1:0];
            end
        end
    end

    always_comb
    begin
        rsp_new.read_data = '0;
        if (req.action == ACT_READ)
        begin
            priority if (req.register_address == REG_INT_ENA)
            begin
                rsp_new.read_data = 32'(ien_reg);
            end
            else if (req.register_address == REG_INT_RAW)
            begin
                rsp_new.read_data = 32'(raw_reg);
            end
            else if (here)
            begin
                rsp_new.read_data = rd_timer;
            end
        end

        rsp_new.interrupt_lines = '0;
        for (int b = 0; b < IRQ_W; b++)
        begin
            if (b < NUM_TIMERS)
            begin
                rsp_new.interrupt_lines[b] = raw_next[b] & ien_next[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ien_reg <= '0;
            raw_reg <= '0;
        end
        else
        begin
            ien_reg <= ien_next;
            raw_reg <= raw_next;
        end
    end

    // The skid slot only fills while the output register holds a stalled beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_valid_reg <= in_accept;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_data_reg <= rsp_new;
        end
        else if (in_accept)
        begin
            skid_data_reg <= rsp_new;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_data       = out_data_reg.read_data;
    assign rsp.interrupt_lines = out_data_reg.interrupt_lines;

    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("Skid slot holds a beat while the output register is empty.");

    a_ien_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && (req.action == ACT_WRITE) && (req.register_address == REG_INT_ENA))
        |=> (ien_reg == $past(req.write_data[NUM_TIMERS-1:0]))
    ) else $error("Interrupt enable write did not take effect.");

    a_raw_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && (req.action == ACT_WRITE) && (req.register_address == REG_INT_CLR))
        |=> ((raw_reg & $past(req.write_data[NUM_TIMERS-1:0])) == '0)
    ) else $error("Interrupt clear left a cleared raw bit set.");

endmodule
